FILE: sv/lms_eq_pkg.sv
// Shared constants and types for the complex LMS equaliser.
// No dependencies.
`default_nettype none
package lms_eq_pkg;
    localparam int MaxTaps   = 32;
    localparam int TapW      = 5;
    localparam int SampleW   = 16;
    localparam int WeightW   = 18;
    localparam int WeightFrac = WeightW - 4;
    localparam int UpdShift  = 16 + 2 * (SampleW - 3) - WeightFrac;
    localparam logic [5:0] TapsReset = 6'd16;
    localparam logic [15:0] StepReset = 16'd328;
    localparam logic [0:0] CfgTaps = 1'b0;
    localparam logic [0:0] CfgStep = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FILT  = 5'b00010,
        ST_ERR   = 5'b00100,
        ST_UPD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    typedef struct packed {
        logic signed [WeightW-1:0] re;
        logic signed [WeightW-1:0] im;
    } weight_t;

    typedef struct packed {
        logic signed [SampleW-1:0] re;
        logic signed [SampleW-1:0] im;
    } sample_t;

    function automatic logic signed [SampleW-1:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) return 16'sh7fff;
        if (v < -48'sd32768) return 16'sh8000;
        return v[SampleW-1:0];
    endfunction
endpackage
`default_nettype wire

FILE: sv/lms_adaptive_equaliser.sv
// Complex LMS adaptive FIR equaliser top level.
// Depends on lms_eq_pkg. Weight and history stores are local synchronous RAMs.
//
// channel   dir  fields
// s_axis    in   tuser: cmd; tdata: in_re, in_im, desired_re, desired_im
// m_axis    out  tdata: y_re, y_im, err_re, err_im
// cfg       in   we, idx, data (taps_in_use, step_size)
//
// Each item takes a filter pass and then an update pass, set by the complex MAC that
// walks the weight and history RAMs twice; the next item can be accepted in the cycle
// after its result is loaded, so items do not overlap.
// After reset a clearing pass over all 32 RAM entries runs before the first item is accepted.
// A result waiting in the output register only holds the next item at its last step.
`default_nettype none
module lms_adaptive_equaliser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // in_re, in_im, desired_re, desired_im
    input  wire logic        s_axis_tuser,  // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // y_re, y_im, err_re, err_im
    input  wire logic        cfg_we,
    input  wire logic        cfg_idx,
    input  wire logic [15:0] cfg_data
);
    import lms_eq_pkg::*;

    state_t state_reg, state_next;
    logic [5:0]  taps_reg;
    logic [15:0] step_reg;
    logic [TapW-1:0] wp_reg, wpu;
    logic [TapW:0]   clr_reg;
    logic        clearing;
    logic [TapW:0] k_reg;      // issue counter
    logic        rv_reg;       // read data valid
    logic [TapW-1:0] rk_reg;   // tap index of read data
    logic        cmd_reg;
    sample_t     des_reg;
    logic signed [47:0] acc_re_reg, acc_im_reg;
    logic signed [SampleW-1:0] y_re_reg, y_im_reg, e_re_reg, e_im_reg;
    logic [63:0] res_reg;
    logic        res_load;
    logic        ov_reg;
    logic        done_reg;

    weight_t wmem [MaxTaps];
    sample_t hmem [MaxTaps];
    weight_t wrd;
    sample_t hrd;
    logic    wwe, hwe;
    logic [TapW-1:0] wwa, hwa, ra, ha;
    weight_t wwd;
    sample_t hwd;

    logic [TapW-1:0] n_m1;
    assign n_m1 = TapW'(taps_reg - 6'd1);
    assign clearing = !clr_reg[TapW];
    assign wpu = ({1'b0, wp_reg} >= taps_reg) ? '0 : wp_reg;

    // history address for tap k: (wp - k) mod n
    logic [TapW:0] hdiff;
    assign hdiff = {1'b0, wp_reg} - {1'b0, k_reg[TapW-1:0]};
    assign ha = hdiff[TapW] ? TapW'(hdiff + {1'b0, taps_reg[TapW-1:0]} +
                              (taps_reg[TapW] ? 6'd32 : 6'd0)) : hdiff[TapW-1:0];
    assign ra = k_reg[TapW-1:0];

    always_ff @(posedge clk)
    begin
        if (wwe) wmem[wwa] <= wwd;
        if (hwe) hmem[hwa] <= hwd;
        wrd <= wmem[ra];
        hrd <= hmem[ha];
    end

    // products
    logic signed [35:0] p1, p2, p3, p4;
    logic signed [47:0] urs, uis, wre_n, wim_n;
    logic signed [SampleW-1:0] xr, xi;
    // sample read-through: entry at write pointer was written with this item
    assign xr = hrd.re;
    assign xi = hrd.im;
    always_comb
    begin
        p1 = 36'(wrd.re * xr);
        p2 = 36'(wrd.im * xi);
        p3 = 36'(wrd.re * xi);
        p4 = 36'(wrd.im * xr);
    end
    // update terms (multiply by mu in following stage)
    logic signed [32:0] ure_reg, uim_reg;
    logic [TapW-1:0] uk_reg;
    logic uv_reg;
    weight_t uw_reg;
    logic signed [49:0] mr, mi;
    always_comb
    begin
        mr = 50'(ure_reg * $signed({1'b0, step_reg}));
        mi = 50'(uim_reg * $signed({1'b0, step_reg}));
        urs = 48'(mr >>> UpdShift);
        uis = 48'(mi >>> UpdShift);
        wre_n = 48'(uw_reg.re) + urs;
        wim_n = 48'(uw_reg.im) + uis;
    end
    function automatic logic signed [WeightW-1:0] satw(input logic signed [47:0] v);
        if (v > 48'sd131071) return 18'sh1ffff;
        if (v < -48'sd131072) return 18'sh20000;
        return v[WeightW-1:0];
    endfunction

    logic signed [47:0] yr_s, yi_s, er_s, ei_s;
    logic signed [SampleW-1:0] dre, dim;
    always_comb
    begin
        yr_s = acc_re_reg >>> WeightFrac;
        yi_s = acc_im_reg >>> WeightFrac;
        dre = cmd_reg ? ((y_re_reg > 0) ? 16'sh2000 : -16'sh2000) : des_reg.re;
        dim = cmd_reg ? ((y_im_reg > 0) ? 16'sh2000 : -16'sh2000) : des_reg.im;
        er_s = 48'(dre) - 48'(y_re_reg);
        ei_s = 48'(dim) - 48'(y_im_reg);
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !clearing;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = res_reg;
    assign res_load = (state_reg == ST_OUT) && !uv_reg && (!ov_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        wwe = 1'b0; wwa = uk_reg; wwd = '{re: satw(wre_n), im: satw(wim_n)};
        hwe = 1'b0; hwa = wpu; hwd = '{re: s_axis_tdata[15:0], im: s_axis_tdata[31:16]};
        if (clearing)
        begin
            wwe = 1'b1; hwe = 1'b1; wwa = clr_reg[TapW-1:0]; hwa = clr_reg[TapW-1:0];
            hwd = '0;
            wwd = '{re: (clr_reg[TapW-1:0] == TapW'(TapsReset >> 1)) ?
                        18'sd16384 : 18'sd0, im: 18'sd0};
        end
        else if (s_axis_tvalid && s_axis_tready)
            hwe = 1'b1;
        if (uv_reg) wwe = 1'b1;
        case (state_reg)
            ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = ST_FILT;
            ST_FILT: if (done_reg) state_next = ST_ERR;
            ST_ERR:  state_next = ST_UPD;
            ST_UPD:  if (done_reg) state_next = ST_OUT;
            ST_OUT:  if (res_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE; taps_reg <= TapsReset; step_reg <= StepReset;
            wp_reg <= '0; clr_reg <= '0; ov_reg <= 1'b0; rv_reg <= 1'b0;
            uv_reg <= 1'b0; done_reg <= 1'b0; k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing) clr_reg <= clr_reg + 1'b1;
            if (cfg_we)
            begin
                if (cfg_idx == CfgTaps)
                    taps_reg <= (cfg_data[5:0] == 6'd0) ? 6'd1 :
                                (cfg_data[5:0] > 6'(MaxTaps)) ? 6'(MaxTaps) : cfg_data[5:0];
                else
                    step_reg <= cfg_data;
            end
            rv_reg <= (state_reg == ST_FILT || state_reg == ST_UPD) && !done_reg &&
                      (k_reg <= {1'b0, n_m1});
            done_reg <= rv_reg && (state_reg == ST_FILT || state_reg == ST_UPD) &&
                        (rk_reg == n_m1);
            uv_reg <= rv_reg && (state_reg == ST_UPD);
            case (state_reg)
                ST_IDLE:
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        wp_reg <= wpu; k_reg <= '0;
                    end
                ST_FILT, ST_UPD:
                    if (!done_reg && k_reg <= {1'b0, n_m1})
                    begin
                        rk_reg <= k_reg[TapW-1:0];
                        k_reg <= k_reg + 1'b1;
                    end
                default: ;
            endcase
            if (state_reg == ST_ERR) k_reg <= '0;
            if (res_load)
            begin
                ov_reg <= 1'b1;
                wp_reg <= ({1'b0, wp_reg} == {1'b0, n_m1}) ? '0 : wp_reg + 1'b1;
            end
            else if (m_axis_tready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            acc_re_reg <= '0; acc_im_reg <= '0;
            cmd_reg <= s_axis_tuser;
            des_reg <= '{re: s_axis_tdata[47:32], im: s_axis_tdata[63:48]};
        end
        if (rv_reg && state_reg == ST_FILT)
        begin
            acc_re_reg <= acc_re_reg + 48'(p1) + 48'(p2);
            acc_im_reg <= acc_im_reg + 48'(p3) - 48'(p4);
        end
        if (state_reg == ST_FILT && done_reg)
        begin
            y_re_reg <= sat16(yr_s);
            y_im_reg <= sat16(yi_s);
        end
        if (state_reg == ST_ERR)
        begin
            e_re_reg <= sat16(er_s);
            e_im_reg <= sat16(ei_s);
        end
        if (rv_reg && state_reg == ST_UPD)
        begin
            ure_reg <= 33'(e_re_reg * xr) + 33'(e_im_reg * xi);
            uim_reg <= 33'(e_im_reg * xr) - 33'(e_re_reg * xi);
            uw_reg <= wrd; uk_reg <= rk_reg;
        end
        if (res_load)
            res_reg <= {e_im_reg, e_re_reg, y_im_reg, y_re_reg};
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> state_reg == ST_FILT)
        else $error("item accept did not start filter pass");
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s_axis_tready)
        else $error("item accepted during clearing pass");
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, wp_reg} < taps_reg) || state_reg == ST_IDLE || state_reg == ST_OUT)
        else $error("write pointer outside ring during pass");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("waiting result changed");
endmodule
`default_nettype wire
